// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/xsr_pkg.sv =====
// Types and constants of the xorshift128 random unit.
package xsr_pkg;

    localparam int WORD_W    = 32;
    localparam int WORDS     = 4;
    localparam int SEED_BYTES = 16;
    localparam int DIV_STEPS = 32;
    localparam int SHIFT_A   = 11;
    localparam int SHIFT_B   = 8;
    localparam int SHIFT_C   = 19;

    localparam logic [2:0] OP_DRAW32  = 3'd0;
    localparam logic [2:0] OP_DRAW64  = 3'd1;
    localparam logic [2:0] OP_BOUNDED = 3'd2;
    localparam logic [2:0] OP_SEED    = 3'd3;
    localparam logic [2:0] OP_DEFAULT = 3'd4;

    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;

    localparam logic [2:0] CFG_SEED_WORD0 = 3'd0;
    localparam logic [2:0] CFG_SEED_WORD1 = 3'd1;
    localparam logic [2:0] CFG_SEED_WORD2 = 3'd2;
    localparam logic [2:0] CFG_SEED_WORD3 = 3'd3;
    localparam logic [2:0] CFG_SEED_COUNT = 3'd4;

    localparam logic [31:0] FILL_LEFT  = 32'hB71A1F9B;
    localparam logic [31:0] FILL_RIGHT = 32'h09359117;

    typedef logic [WORDS-1:0][WORD_W-1:0] t_words;

    localparam t_words DEFAULT_WORDS = {32'hBD1A8DF8, 32'h5FF57607,
                                        32'h125E16C8, 32'h418B2B91};

    typedef enum logic [2:0] {
        KIND_DRAW32,
        KIND_DRAW64,
        KIND_BOUNDED,
        KIND_SEED,
        KIND_DEFAULT,
        KIND_NOP
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HIGH,
        ST_DIVIDE
    } t_state;

    typedef struct packed {
        logic [2:0]  op;
        logic [1:0]  draw_width;
        logic [63:0] bound;
    } t_req;

    typedef struct packed {
        logic [63:0] value;
        logic        bound_error;
    } t_rsp;

    typedef struct packed {
        t_kind       kind;
        logic [1:0]  draw_width;
        logic [63:0] bound;
    } t_cmd;

    typedef struct packed {
        t_words     word;
        logic [4:0] count;
    } t_seed_cfg;

endpackage

// ===== hdl/xsr_front.sv =====
// Request decode and command queue of the xorshift128 random unit.
module xsr_front #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  xsr_pkg::t_req i_req,
    output logic          o_full,
    output logic          o_cmd_valid,
    output xsr_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    xsr_pkg::t_cmd r_queue [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    xsr_pkg::t_cmd w_cmd;
    logic w_push;
    logic w_pop;

    // classify the request
    always_comb begin
        w_cmd.draw_width = i_req.draw_width;
        w_cmd.bound      = i_req.bound;
        case (i_req.op)
            xsr_pkg::OP_DRAW32:  w_cmd.kind = xsr_pkg::KIND_DRAW32;
            xsr_pkg::OP_DRAW64:  w_cmd.kind = xsr_pkg::KIND_DRAW64;
            xsr_pkg::OP_BOUNDED: w_cmd.kind = xsr_pkg::KIND_BOUNDED;
            xsr_pkg::OP_SEED:    w_cmd.kind = xsr_pkg::KIND_SEED;
            xsr_pkg::OP_DEFAULT: w_cmd.kind = xsr_pkg::KIND_DEFAULT;
            default:             w_cmd.kind = xsr_pkg::KIND_NOP;
        endcase
    end

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_rd_ptr];
    assign w_push      = i_push && !o_full;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

// ===== hdl/xsr_back.sv =====
// Generator state, bounded-draw remainder unit and result register.
module xsr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  xsr_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    input  xsr_pkg::t_seed_cfg i_seed,
    input  logic               i_pop,
    output logic               o_empty,
    output xsr_pkg::t_rsp      o_rsp
);

    xsr_pkg::t_state r_state, n_state;
    xsr_pkg::t_words r_words, n_words;
    logic            r_out_valid, n_out_valid;
    xsr_pkg::t_rsp   r_out, n_out;
    logic [31:0]     r_lo, n_lo;
    logic [31:0]     r_rem, n_rem;
    logic [31:0]     r_dvd, n_dvd;
    logic [63:0]     r_bound, n_bound;
    logic [4:0]      r_step, n_step;

    logic            w_take;
    logic [31:0]     w_t0;
    logic [31:0]     w_t1;
    logic [31:0]     w_draw;
    xsr_pkg::t_words w_adv;
    xsr_pkg::t_words w_merge;
    xsr_pkg::t_words w_seeded;
    logic [4:0]      w_count;
    logic [32:0]     w_trial;
    logic            w_ge;
    logic [63:0]     w_diff;

    assign w_take    = (r_state == xsr_pkg::ST_IDLE) && i_cmd_valid && !r_out_valid;
    assign o_cmd_pop = w_take;
    assign o_empty   = !r_out_valid;
    assign o_rsp     = r_out;

    // one generator step
    assign w_t0   = r_words[3] ^ (r_words[3] << xsr_pkg::SHIFT_A);
    assign w_t1   = w_t0 ^ (w_t0 >> xsr_pkg::SHIFT_B);
    assign w_draw = w_t1 ^ r_words[0] ^ (r_words[0] >> xsr_pkg::SHIFT_C);
    assign w_adv  = {r_words[2], r_words[1], r_words[0], w_draw};

    // seed bytes over state, then replace zero words
    assign w_count = (i_seed.count > 5'(xsr_pkg::SEED_BYTES)) ?
                     5'(xsr_pkg::SEED_BYTES) : i_seed.count;

    always_comb begin
        w_merge  = r_words;
        w_seeded = r_words;
        for (int w = 0; w < xsr_pkg::WORDS; w++) begin
            for (int k = 0; k < 4; k++) begin
                if (5'(w * 4 + k) < w_count) begin
                    w_merge[w][k*8 +: 8] = i_seed.word[w][k*8 +: 8];
                end
            end
        end
        for (int w = 0; w < xsr_pkg::WORDS; w++) begin
            if (w_merge[w] == '0) begin
                w_seeded[w] = 32'(xsr_pkg::FILL_LEFT << w) ^ (xsr_pkg::FILL_RIGHT >> w);
            end else begin
                w_seeded[w] = w_merge[w];
            end
        end
    end

    // one restoring remainder step
    assign w_trial = {r_rem, r_dvd[31]};
    assign w_ge    = ({31'b0, w_trial} >= r_bound);
    assign w_diff  = {31'b0, w_trial} - r_bound;

    always_comb begin
        n_state = r_state;
        case (r_state)
            xsr_pkg::ST_IDLE: begin
                if (w_take) begin
                    if (i_cmd.kind == xsr_pkg::KIND_DRAW64) begin
                        n_state = xsr_pkg::ST_HIGH;
                    end else if (i_cmd.kind == xsr_pkg::KIND_BOUNDED &&
                                 i_cmd.bound != '0) begin
                        n_state = xsr_pkg::ST_DIVIDE;
                    end
                end
            end
            xsr_pkg::ST_HIGH: n_state = xsr_pkg::ST_IDLE;
            xsr_pkg::ST_DIVIDE: begin
                if (r_step == 5'(xsr_pkg::DIV_STEPS - 1)) begin
                    n_state = xsr_pkg::ST_IDLE;
                end
            end
            default: n_state = xsr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_words     = r_words;
        n_out_valid = r_out_valid && !i_pop;
        n_out       = r_out;
        n_lo        = r_lo;
        n_rem       = r_rem;
        n_dvd       = r_dvd;
        n_bound     = r_bound;
        n_step      = r_step;
        case (r_state)
            xsr_pkg::ST_IDLE: begin
                if (w_take) begin
                    n_out       = '0;
                    n_out_valid = 1'b1;
                    case (i_cmd.kind)
                        xsr_pkg::KIND_DRAW32: begin
                            n_words = w_adv;
                            case (i_cmd.draw_width)
                                xsr_pkg::WIDTH_8:  n_out.value = {56'b0, w_draw[7:0]};
                                xsr_pkg::WIDTH_16: n_out.value = {48'b0, w_draw[15:0]};
                                default:           n_out.value = {32'b0, w_draw};
                            endcase
                        end
                        xsr_pkg::KIND_DRAW64: begin
                            n_words     = w_adv;
                            n_lo        = w_draw;
                            n_out_valid = 1'b0;
                        end
                        xsr_pkg::KIND_BOUNDED: begin
                            n_words = w_adv;
                            if (i_cmd.bound == '0) begin
                                n_out.bound_error = 1'b1;
                            end else begin
                                n_out_valid = 1'b0;
                                n_dvd       = w_draw;
                                n_rem       = '0;
                                n_bound     = i_cmd.bound;
                                n_step      = '0;
                            end
                        end
                        xsr_pkg::KIND_SEED:    n_words = w_seeded;
                        xsr_pkg::KIND_DEFAULT: n_words = xsr_pkg::DEFAULT_WORDS;
                        default:               n_words = r_words;
                    endcase
                end
            end
            xsr_pkg::ST_HIGH: begin
                n_words     = w_adv;
                n_out       = '0;
                n_out.value = {w_draw, r_lo};
                n_out_valid = 1'b1;
            end
            xsr_pkg::ST_DIVIDE: begin
                n_rem  = w_ge ? w_diff[31:0] : w_trial[31:0];
                n_dvd  = r_dvd << 1;
                n_step = r_step + 1'b1;
                if (r_step == 5'(xsr_pkg::DIV_STEPS - 1)) begin
                    n_out       = '0;
                    n_out.value = {32'b0, n_rem};
                    n_out_valid = 1'b1;
                end
            end
            default: n_words = r_words;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= xsr_pkg::ST_IDLE;
            r_words     <= xsr_pkg::DEFAULT_WORDS;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            r_state     <= n_state;
            r_words     <= n_words;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_lo    <= n_lo;
        r_rem   <= n_rem;
        r_dvd   <= n_dvd;
        r_bound <= n_bound;
    end

endmodule

// ===== hdl/xorshift128_random_unit_top.sv =====
// Top level of the xorshift128 random unit: seed registers, front and back.
// Requests enter a command queue of QUEUE_DEPTH entries and are carried out
// one at a time by the back end, which holds the four generator words and a
// one-entry result register. Draw32, seed, default and unknown requests end
// in ST_IDLE; a draw64 steps the generator there and again in ST_HIGH; a
// bounded draw with a nonzero bound takes one step, then runs the bit-serial
// remainder unit. A new request starts once the previous result is popped;
// requests keep queueing meanwhile. The configuration port never stalls.
`include "assert_macros.svh"

module xorshift128_random_unit_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  xsr_pkg::t_req i_req,
    output logic          o_empty,
    input  logic          i_pop,
    output xsr_pkg::t_rsp o_rsp,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);

    xsr_pkg::t_seed_cfg r_seed;
    logic               w_cmd_valid;
    xsr_pkg::t_cmd      w_cmd;
    logic               w_cmd_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed.word  <= '0;
            r_seed.count <= 5'(xsr_pkg::SEED_BYTES);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                xsr_pkg::CFG_SEED_WORD0: r_seed.word[0] <= i_cfg_data;
                xsr_pkg::CFG_SEED_WORD1: r_seed.word[1] <= i_cfg_data;
                xsr_pkg::CFG_SEED_WORD2: r_seed.word[2] <= i_cfg_data;
                xsr_pkg::CFG_SEED_WORD3: r_seed.word[3] <= i_cfg_data;
                xsr_pkg::CFG_SEED_COUNT: r_seed.count   <= i_cfg_data[4:0];
                default: r_seed <= r_seed;
            endcase
        end
    end

    xsr_front #(
        .DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_req      (i_req),
        .o_full     (o_full),
        .o_cmd_valid(w_cmd_valid),
        .o_cmd      (w_cmd),
        .i_cmd_pop  (w_cmd_pop)
    );

    xsr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(w_cmd_valid),
        .i_cmd      (w_cmd),
        .o_cmd_pop  (w_cmd_pop),
        .i_seed     (r_seed),
        .i_pop      (i_pop),
        .o_empty    (o_empty),
        .o_rsp      (o_rsp)
    );

    `ASSERT_CLK(a_pop_needs_cmd, i_clk, i_rst_n, w_cmd_pop |-> w_cmd_valid, "pop of empty queue")
    `ASSERT_CLK(a_full_has_cmd, i_clk, i_rst_n, o_full |-> w_cmd_valid, "full queue shows no item")
    `ASSERT_CLK(a_err_zero, i_clk, i_rst_n, (!o_empty && o_rsp.bound_error) |-> (o_rsp.value == '0), "bound error with value")

endmodule
